@@ design/tkml_pkg.sv @@
// Package for the top-K match list: list geometry, opcodes, transfer structs
// and the internal control structs shared by the list, compare and top modules.
// No dependencies.
package tkml_pkg;

    localparam int LIST_DEPTH  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int DUMP_COUNT  = (LIST_DEPTH < MAX_RESULTS) ? LIST_DEPTH : MAX_RESULTS;

    localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(LIST_DEPTH - 1);
    localparam logic [IDX_W-1:0] DUMP_LAST_IDX = IDX_W'(DUMP_COUNT - 1);

    localparam logic [31:0] INF_DIST = 32'hFFFF_FFFF;

    // opcodes
    localparam logic [1:0] OP_OFFER = 2'd0;
    localparam logic [1:0] OP_DUMP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // APB register word index (paddr[2])
    localparam logic REG_BLACKOUT = 1'b0;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] distance;
        logic [15:0] seed_index;
        logic [19:0] cand_index;
        logic [31:0] cand_start;
        logic [15:0] file_id;
    } t_in_item;

    typedef struct packed {
        logic [31:0] worst_distance;
        logic [31:0] out_distance;
        logic [15:0] out_seed;
        logic [19:0] out_cand;
        logic [15:0] out_file;
        logic        out_valid;
        logic        out_fresh;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] distance;
        logic [15:0] seed;
        logic [19:0] cand;
        logic [15:0] file;
        logic [31:0] start;
        logic        valid;
        logic        fresh;
    } t_entry;

    // write side of the list storage
    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic             ack_en;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_list_wr;

    // compare unit verdict for one entry
    typedef struct packed {
        logic larger;
        logic neighbor;
    } t_cmp_res;

endpackage

@@ design/top_k_match_list_with_suppression.sv @@
// Top level of the top-K match list with neighbor suppression: APB register,
// command port, sequencer. Uses tkml_pkg, tkml_list and tkml_cmp.
//
// Keeps the LIST_DEPTH best candidates (smallest distance first). A command
// is taken when start is high and busy is low. busy stays high until the
// command's last result is registered; that result shows in the first cycle
// with busy low, so the next command can be taken while it is on the ports.
// Results appear on o_result with o_strobe high for exactly one cycle each
// and cannot be stalled; the receiver must take every transfer. Steps, with
// D = LIST_DEPTH, all set by the single compare unit and the single read
// port of the entry store, one entry per cycle:
//   offer: scan 1..D entries (stops at the first same-file neighbor), then
//          shift 0..D-1 entries down, then a write step and a result step;
//          one result.
//   dump:  min(D,16) entries, one result per entry in list order; the last
//          one carries last=1. Reported entries lose their fresh flag.
//   clear: empties the list, one result with worst_distance all ones.
// Each result is registered and shows in the cycle after the sequencer step
// that made it. blackout_window sits at byte address 0 and must only be
// written while busy is low and no result is pending.
module top_k_match_list_with_suppression (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // command side
    input  logic                start,
    output logic                busy,
    input  tkml_pkg::t_in_item  i_item,
    // result side
    output logic                o_strobe,
    output tkml_pkg::t_out_item o_result
);
    import tkml_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_SHIFT = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_DUMP  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    t_in_item         r_item;
    logic [31:0]      r_window;
    logic [IDX_W-1:0] r_idx, n_idx;     // scan / shift / dump position
    logic [IDX_W-1:0] r_ins, n_ins;     // insert point
    logic             r_found, n_found; // insert point seen
    logic             r_strobe, n_strobe;
    t_out_item        r_out, n_out;

    t_list_wr         list_wr;
    logic [IDX_W-1:0] rd_idx;
    t_entry           rd_entry;
    logic [31:0]      worst;
    t_cmp_res         cmp;

    logic             accept;
    logic [IDX_W-1:0] scan_ins;
    logic [IDX_W-1:0] scan_end;
    logic             scan_found;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BLACKOUT) ? r_window : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_BLACKOUT)) begin
            r_window <= pwdata;
        end
    end

    // ---------------- datapath parts ----------------
    tkml_list u_list (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (list_wr),
        .i_rd_idx   (rd_idx),
        .o_rd_entry (rd_entry),
        .o_worst    (worst)
    );

    tkml_cmp u_cmp (
        .i_entry  (rd_entry),
        .i_item   (r_item),
        .i_window (r_window),
        .o_res    (cmp)
    );

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // insert point and end of the shifted run as seen at this scan step
    assign scan_found = r_found || cmp.larger;
    assign scan_ins   = r_found ? r_ins : r_idx;
    assign scan_end   = cmp.neighbor ? r_idx : LAST_IDX;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_ins    = r_ins;
        n_found  = r_found;
        n_strobe = 1'b0;
        n_out    = '0;
        rd_idx   = r_idx;
        list_wr  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    unique case (i_item.op)
                        OP_OFFER: n_state = ST_SCAN;
                        OP_DUMP:  n_state = ST_DUMP;
                        OP_CLEAR: begin
                            list_wr.clear = 1'b1;
                            n_state       = ST_DONE;
                        end
                        default:  n_state = ST_DONE;   // unused code: just report
                    endcase
                end
            end

            ST_SCAN: begin
                n_found = scan_found;
                n_ins   = scan_ins;
                if (cmp.neighbor || r_idx == LAST_IDX) begin
                    if (!scan_found) begin
                        n_state = ST_DONE;           // nothing kept
                    end else if (scan_end == scan_ins) begin
                        n_state = ST_WRITE;          // append or replace in place
                    end else begin
                        n_idx   = scan_end;
                        n_state = ST_SHIFT;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            ST_SHIFT: begin
                // move entry idx-1 down into idx
                rd_idx        = r_idx - 1'b1;
                list_wr.wr_en = 1'b1;
                list_wr.idx   = r_idx;
                list_wr.entry = rd_entry;
                n_idx         = r_idx - 1'b1;
                if (r_idx - 1'b1 == r_ins) begin
                    n_state = ST_WRITE;
                end
            end

            ST_WRITE: begin
                list_wr.wr_en = 1'b1;
                list_wr.idx   = r_ins;
                list_wr.entry = '{distance: r_item.distance,
                                  seed:     r_item.seed_index,
                                  cand:     r_item.cand_index,
                                  file:     r_item.file_id,
                                  start:    r_item.cand_start,
                                  valid:    1'b1,
                                  fresh:    1'b1};
                n_state = ST_DONE;
            end

            ST_DONE: begin
                n_strobe             = 1'b1;
                n_out.worst_distance = worst;
                n_out.last           = 1'b1;
                n_state              = ST_IDLE;
            end

            ST_DUMP: begin
                n_strobe             = 1'b1;
                n_out.worst_distance = worst;
                n_out.out_distance   = rd_entry.distance;
                n_out.out_seed       = rd_entry.seed;
                n_out.out_cand       = rd_entry.cand;
                n_out.out_file       = rd_entry.file;
                n_out.out_valid      = rd_entry.valid;
                n_out.out_fresh      = rd_entry.fresh;
                list_wr.ack_en       = 1'b1;   // reported: no longer fresh
                list_wr.idx          = r_idx;
                if (r_idx == DUMP_LAST_IDX) begin
                    n_out.last = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_ins    <= '0;
            r_found  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ins    <= n_ins;
            r_found  <= n_found;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

@@ design/tkml_list.sv @@
// Entry storage of the top-K match list: one register row per entry,
// one indexed read port, one write port and a clear of all rows. Uses tkml_pkg.
module tkml_list (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tkml_pkg::t_list_wr        i_wr,
    input  logic [tkml_pkg::IDX_W-1:0] i_rd_idx,
    output tkml_pkg::t_entry          o_rd_entry,
    output logic [31:0]               o_worst
);
    import tkml_pkg::*;

    t_entry r_slot [LIST_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clear) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
                r_slot[i] <= '{distance: INF_DIST, default: '0};
            end
        end else begin
            if (i_wr.wr_en) begin
                r_slot[i_wr.idx] <= i_wr.entry;
            end
            if (i_wr.ack_en) begin
                r_slot[i_wr.idx].fresh <= 1'b0;
            end
        end
    end

    assign o_rd_entry = r_slot[i_rd_idx];
    assign o_worst    = r_slot[LIST_DEPTH-1].distance;

endmodule

@@ design/tkml_cmp.sv @@
// Shared compare unit: checks one stored entry against the pending offer
// (distance order and blackout neighbor test). Uses tkml_pkg.
module tkml_cmp (
    input  tkml_pkg::t_entry   i_entry,
    input  tkml_pkg::t_in_item i_item,
    input  logic [31:0]        i_window,
    output tkml_pkg::t_cmp_res o_res
);
    import tkml_pkg::*;

    logic [31:0] gap;

    always_comb begin
        // absolute start difference, no wrap
        if (i_entry.start > i_item.cand_start) begin
            gap = i_entry.start - i_item.cand_start;
        end else begin
            gap = i_item.cand_start - i_entry.start;
        end
        o_res.larger   = i_entry.distance > i_item.distance;
        o_res.neighbor = i_entry.valid && (i_entry.file == i_item.file_id) && (gap < i_window);
    end

endmodule

@@ bench/tb.sv @@
// Testbench for top_k_match_list_with_suppression: directed table, then random phases.
// A shadow copy of the match list predicts every result transfer.
// Depends on tkml_pkg and the top_k_match_list_with_suppression RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tkml_pkg::*;

    // opcode 3 is unused; the block answers it like an offer that keeps nothing
    localparam logic [1:0]  OP_NOP        = 2'd3;
    localparam logic [2:0]  BLACKOUT_ADDR = {REG_BLACKOUT, 2'b00};
    localparam int          N_DIRECTED    = 21;
    localparam int          N_PHASES      = 5;
    localparam int          PHASE_ITEMS   = 54;
    localparam int          DRAIN_CYCLES  = 2 * LIST_DEPTH + 8;

    typedef struct packed {
        logic        cfg;     // row programs blackout_window instead of a command
        logic [31:0] window;
        t_in_item    item;
        logic        typed;   // single result, worst distance written out below
        logic [31:0] worst;
    } t_stim_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start   = 1'b0;
    logic        busy;
    t_in_item    i_item  = '0;
    logic        o_strobe;
    t_out_item   o_result;

    // shadow of the list and register, plus result transfers still owed
    t_entry      shadow_list [LIST_DEPTH];
    logic [31:0] shadow_window = '0;
    t_out_item   due_reports [$];
    int          mismatch_count = 0;
    logic        no_idle = 1'b0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        // unused opcode right after reset, every input bit high
        '{1'b0, 32'd0, '{OP_NOP, INF_DIST, 16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF, 16'hFFFF},
          1'b1, INF_DIST},
        '{1'b0, 32'd0, '{OP_DUMP, 32'd0, 16'd0, 20'd0, 32'd0, 16'd0}, 1'b0, 32'd0},
        // smallest distance, top field values
        '{1'b0, 32'd0, '{OP_OFFER, 32'd0, 16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF, 16'hFFFF},
          1'b1, INF_DIST},
        // infinite distance is never kept
        '{1'b0, 32'd0, '{OP_OFFER, INF_DIST, 16'd1, 20'd1, 32'd0, 16'd0}, 1'b1, INF_DIST},
        '{1'b0, 32'd0, '{OP_OFFER, 32'd100, 16'd1, 20'd1, 32'd1000, 16'd1}, 1'b0, 32'd0},
        // same file and start, window 0: no neighbor, equal distance goes behind
        '{1'b0, 32'd0, '{OP_OFFER, 32'd100, 16'd2, 20'd2, 32'd1000, 16'd1}, 1'b0, 32'd0},
        '{1'b1, 32'd50, '0, 1'b0, 32'd0},
        // neighbor at the insert point: replaced
        '{1'b0, 32'd0, '{OP_OFFER, 32'd50, 16'd3, 20'd3, 32'd1020, 16'd1}, 1'b0, 32'd0},
        // neighbor ahead of any larger entry: list unchanged
        '{1'b0, 32'd0, '{OP_OFFER, 32'd200, 16'd4, 20'd4, 32'd1010, 16'd1}, 1'b0, 32'd0},
        '{1'b0, 32'd0, '{OP_OFFER, 32'd40, 16'd5, 20'd5, 32'd1000, 16'd2}, 1'b0, 32'd0},
        // neighbor further down: entries shift and the neighbor drops out
        '{1'b0, 32'd0, '{OP_OFFER, 32'd5, 16'd6, 20'd6, 32'd1030, 16'd1}, 1'b0, 32'd0},
        // gap equal to the window is not a neighbor
        '{1'b0, 32'd0, '{OP_OFFER, 32'd1, 16'd7, 20'd7, 32'd1050, 16'd2}, 1'b0, 32'd0},
        '{1'b0, 32'd0, '{OP_DUMP, 32'd0, 16'd0, 20'd0, 32'd0, 16'd0}, 1'b0, 32'd0},
        // second dump: fresh flags already acknowledged
        '{1'b0, 32'd0, '{OP_DUMP, 32'd0, 16'd0, 20'd0, 32'd0, 16'd0}, 1'b0, 32'd0},
        '{1'b1, 32'hFFFF_FFFF, '0, 1'b0, 32'd0},
        // starts 0 and all ones: gap is all ones, not below the widest window
        '{1'b0, 32'd0, '{OP_OFFER, 32'd0, 16'd8, 20'd8, 32'd0, 16'hFFFF}, 1'b0, 32'd0},
        '{1'b0, 32'd0, '{OP_OFFER, 32'd2, 16'd9, 20'd9, 32'd7, 16'd1}, 1'b0, 32'd0},
        '{1'b0, 32'd0, '{OP_DUMP, 32'd0, 16'd0, 20'd0, 32'd0, 16'd0}, 1'b0, 32'd0},
        '{1'b0, 32'd0, '{OP_CLEAR, 32'd0, 16'd0, 20'd0, 32'd0, 16'd0}, 1'b1, INF_DIST},
        '{1'b0, 32'd0, '{OP_DUMP, 32'd0, 16'd0, 20'd0, 32'd0, 16'd0}, 1'b0, 32'd0},
        // largest finite distance still beats an empty slot
        '{1'b0, 32'd0, '{OP_OFFER, INF_DIST - 1, 16'd10, 20'd10, 32'd5, 16'd3},
          1'b1, INF_DIST}
    };

    top_k_match_list_with_suppression uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400_000;
        $display("[top_k_match_list_with_suppression] ERROR");
        $finish;
    end

    function automatic void shadow_clear();
        for (int i = 0; i < LIST_DEPTH; i++) begin
            shadow_list[i] = '0;
            shadow_list[i].distance = INF_DIST;
        end
    endfunction

    // Applies one accepted command to the shadow list and queues its results.
    function automatic void shadow_command(input t_in_item cmd);
        int          ins;
        int          nb;
        int          stop;
        logic [31:0] gap;
        t_out_item   rep;
        ins = -1;
        nb  = -1;
        rep = '0;
        if (cmd.op == OP_DUMP) begin
            for (int k = 0; k < DUMP_COUNT; k++) begin
                rep.worst_distance = shadow_list[LIST_DEPTH-1].distance;
                rep.out_distance   = shadow_list[k].distance;
                rep.out_seed       = shadow_list[k].seed;
                rep.out_cand       = shadow_list[k].cand;
                rep.out_file       = shadow_list[k].file;
                rep.out_valid      = shadow_list[k].valid;
                rep.out_fresh      = shadow_list[k].fresh;
                rep.last           = (k == DUMP_COUNT - 1);
                due_reports.push_back(rep);
            end
            for (int k = 0; k < DUMP_COUNT; k++)
                shadow_list[k].fresh = 1'b0;
        end else begin
            if (cmd.op == OP_CLEAR) begin
                shadow_clear();
            end else if (cmd.op == OP_OFFER) begin
                // scan stops at the first same-file entry inside the window
                for (int i = 0; i < LIST_DEPTH; i++) begin
                    if (ins < 0 && shadow_list[i].distance > cmd.distance)
                        ins = i;
                    gap = (shadow_list[i].start > cmd.cand_start) ?
                          shadow_list[i].start - cmd.cand_start :
                          cmd.cand_start - shadow_list[i].start;
                    if (shadow_list[i].valid && shadow_list[i].file == cmd.file_id &&
                        gap < shadow_window) begin
                        nb = i;
                        break;
                    end
                end
                if (ins >= 0) begin
                    stop = (nb < 0) ? LIST_DEPTH - 1 : nb;
                    for (int i = stop; i > ins; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[ins] = '{cmd.distance, cmd.seed_index, cmd.cand_index,
                                         cmd.file_id, cmd.cand_start, 1'b1, 1'b1};
                end
            end
            rep.worst_distance = shadow_list[LIST_DEPTH-1].distance;
            rep.last           = 1'b1;
            due_reports.push_back(rep);
        end
    endfunction

    function automatic t_in_item random_command(input logic [31:0] cluster);
        t_in_item cmd;
        int       sel;
        sel            = $urandom_range(0, 99);
        cmd.op         = (sel < 83) ? OP_OFFER : (sel < 93) ? OP_DUMP :
                         (sel < 97) ? OP_CLEAR : OP_NOP;
        sel            = $urandom_range(0, 99);
        cmd.distance   = (sel < 75) ? 32'($urandom_range(0, 4095)) :
                         (sel < 90) ? 32'($urandom) : (sel < 95) ? INF_DIST : 32'd0;
        cmd.seed_index = 16'($urandom);
        cmd.cand_index = 20'($urandom);
        // mostly a few files with starts bunched together, so neighbors occur
        cmd.file_id    = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 3)) :
                         16'($urandom);
        cmd.cand_start = ($urandom_range(0, 99) < 85) ?
                         cluster + 32'($urandom_range(0, 400)) : 32'($urandom);
        return cmd;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // One command transfer; start stays high from one command to the next
    // when no gap is drawn.
    task automatic send_command(input t_in_item cmd);
        int gap_cycles;
        gap_cycles = no_idle ? 0 : $urandom_range(0, 14);
        if (gap_cycles > 0) begin
            start <= 1'b0;
            repeat (gap_cycles) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd;
        do @(posedge i_clk); while (busy);
        shadow_command(cmd);
    endtask

    // Waits until every owed result has arrived and the block is idle.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (due_reports.size() != 0 || busy);
    endtask

    task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= BLACKOUT_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (wr)
            shadow_window = wdata;
    endtask

    task automatic read_back_window();
        logic [31:0] rd;
        apb_transfer(1'b0, '0, rd);
        check_field("blackout_window", shadow_window, rd);
    endtask

    task automatic program_window(input logic [31:0] value);
        logic [31:0] unused_rd;
        settle();
        apb_transfer(1'b1, value, unused_rd);
        // bus idle between the write and the read-back
        @(posedge i_clk);
        read_back_window();
    endtask

    // Every strobe is a transfer that must match the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (due_reports.size() == 0) begin
                $error("unexpected result transfer: %p", o_result);
                mismatch_count++;
            end else begin
                want = due_reports.pop_front();
                check_field("worst_distance", want.worst_distance, o_result.worst_distance);
                check_field("out_distance", want.out_distance, o_result.out_distance);
                check_field("out_seed", want.out_seed, o_result.out_seed);
                check_field("out_cand", want.out_cand, o_result.out_cand);
                check_field("out_file", want.out_file, o_result.out_file);
                check_field("out_valid", want.out_valid, o_result.out_valid);
                check_field("out_fresh", want.out_fresh, o_result.out_fresh);
                check_field("last", want.last, o_result.last);
            end
        end
    end

    initial begin : stimulus
        t_out_item   typed_rep;
        logic [31:0] phase_window [N_PHASES];
        logic [31:0] cluster;
        shadow_clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_back_window();

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].cfg) begin
                program_window(directed_rows[r].window);
            end else begin
                send_command(directed_rows[r].item);
                if (directed_rows[r].typed) begin
                    // swap the predicted result for the one written in the table
                    void'(due_reports.pop_back());
                    typed_rep                = '0;
                    typed_rep.worst_distance = directed_rows[r].worst;
                    typed_rep.last           = 1'b1;
                    due_reports.push_back(typed_rep);
                end
            end
        end

        // widest window, none, tight, moderate, then a random one
        phase_window = '{32'hFFFF_FFFF, 32'd0, 32'd64, 32'd1000, 32'($urandom)};
        for (int ph = 0; ph < N_PHASES; ph++) begin
            program_window(phase_window[ph]);
            no_idle = (ph == 2) || ($urandom_range(0, 3) == 0);
            cluster = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_command(random_command(cluster));
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[top_k_match_list_with_suppression] OK");
        else
            $display("[top_k_match_list_with_suppression] ERROR");
        $finish;
    end

endmodule
